// ===== hw/rtl/eulr_pkg.sv =====
// shared types, widths and sine polynomial coefficients for the euler rotation unit
`default_nettype none

package eulr_pkg;

  // field widths
  localparam int COORD_WIDTH = 32;
  localparam int ANGLE_WIDTH = 16;
  localparam int TRIG_WIDTH  = 16;
  localparam int TRIG_FRAC   = 15;

  // quarter turn resolution of a binary angle
  localparam int QB = ANGLE_WIDTH - 2;

  // polynomial datapath: FB fraction bits, multiplier operand and accumulator widths
  localparam int FB    = 46;
  localparam int MW    = FB + 1;
  localparam int PW    = FB + 3;
  localparam int SPLIT = 24;

  // taylor terms of the sine polynomial; the top one seeds p, each other one feeds a mac cell
  localparam int NT = 10;

  // pipeline depths
  localparam int SIN_LAT = 2 * NT + 3;
  localparam int ROT_LAT = 2;
  localparam int LAT     = SIN_LAT + 3 * ROT_LAT;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [ANGLE_WIDTH-1:0]        angle_t;
  typedef logic signed [TRIG_WIDTH-1:0]  trig_t;
  typedef logic [MW-1:0]                 frac_t;
  typedef logic signed [PW-1:0]          poly_t;

  // beat handed from one mac cell to the next
  typedef struct packed {
    logic  neg;
    frac_t u;
    frac_t t;
    poly_t p;
  } horn_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec3_t;

  typedef struct packed {
    trig_t c;
    trig_t s;
  } cs_t;

  localparam angle_t QUARTER_TURN = angle_t'(2 ** QB);

  // taylor terms of sin(pi/2 * t) at t = 1, q62, worked out at elaboration
  localparam logic [127:0] HALF_PI_Q62 = 128'h6487ED5110B4611A;
  localparam logic [127:0] HP2 = (HALF_PI_Q62 * HALF_PI_Q62) >> 62;
  localparam logic [127:0] T0  = HALF_PI_Q62;
  localparam logic [127:0] T1  = ((T0 * HP2) >> 62) / 6;
  localparam logic [127:0] T2  = ((T1 * HP2) >> 62) / 20;
  localparam logic [127:0] T3  = ((T2 * HP2) >> 62) / 42;
  localparam logic [127:0] T4  = ((T3 * HP2) >> 62) / 72;
  localparam logic [127:0] T5  = ((T4 * HP2) >> 62) / 110;
  localparam logic [127:0] T6  = ((T5 * HP2) >> 62) / 156;
  localparam logic [127:0] T7  = ((T6 * HP2) >> 62) / 210;
  localparam logic [127:0] T8  = ((T7 * HP2) >> 62) / 272;
  localparam logic [127:0] T9  = ((T8 * HP2) >> 62) / 342;

  localparam int QSH = 62 - FB;

  // q62 magnitude to rounded, signed accumulator format
  function automatic poly_t q62_to_poly(input logic [127:0] v, input logic neg);
    logic [127:0] r;
    r = (v + (128'd1 << (QSH - 1))) >> QSH;
    return neg ? poly_t'(-PW'(r)) : poly_t'(PW'(r));
  endfunction

  localparam poly_t COEF [NT] = '{
    q62_to_poly(T0, 1'b0), q62_to_poly(T1, 1'b1),
    q62_to_poly(T2, 1'b0), q62_to_poly(T3, 1'b1),
    q62_to_poly(T4, 1'b0), q62_to_poly(T5, 1'b1),
    q62_to_poly(T6, 1'b0), q62_to_poly(T7, 1'b1),
    q62_to_poly(T8, 1'b0), q62_to_poly(T9, 1'b1)
  };

endpackage

`default_nettype wire

// ===== hw/rtl/eulr_if.sv =====
// valid/ready stream interfaces for the input and result channels
`default_nettype none

interface eulr_in_if;
  import eulr_pkg::*;

  logic   valid;
  logic   ready;
  coord_t vec_x;
  coord_t vec_y;
  coord_t vec_z;
  angle_t angle_x;
  angle_t angle_y;
  angle_t angle_z;

  modport source (output valid, output vec_x, output vec_y, output vec_z,
                  output angle_x, output angle_y, output angle_z, input ready);
  modport sink   (input valid, input vec_x, input vec_y, input vec_z,
                  input angle_x, input angle_y, input angle_z, output ready);
endinterface

interface eulr_out_if;
  import eulr_pkg::*;

  logic   valid;
  logic   ready;
  coord_t rot_x;
  coord_t rot_y;
  coord_t rot_z;

  modport source (output valid, output rot_x, output rot_y, output rot_z, input ready);
  modport sink   (input valid, input rot_x, input rot_y, input rot_z, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/eulr_mac_cell.sv =====
// one horner step: p_out = coef + u * p_in, two stages, side fields passed along
`default_nettype none

module eulr_mac_cell (
  input  logic           clk,
  input  logic           en,
  input  eulr_pkg::horn_t cell_in,
  input  eulr_pkg::poly_t coef,
  output eulr_pkg::horn_t cell_out
);
  import eulr_pkg::*;

  localparam int MHW = MW - SPLIT;
  localparam int PHW = PW - SPLIT;
  localparam int HHW = MHW + 1 + PHW;
  localparam int HLW = MHW + SPLIT;
  localparam int LHW = SPLIT + 1 + PHW;
  localparam int LLW = 2 * SPLIT;
  localparam int SW  = MW + PW + 1;

  logic [MHW-1:0]          mh;
  logic [SPLIT-1:0]        ml;
  logic signed [PHW-1:0]   ph;
  logic [SPLIT-1:0]        pl;

  logic signed [HHW-1:0]   hh_r;
  logic [HLW-1:0]          hl_r;
  logic signed [LHW-1:0]   lh_r;
  logic [LLW-1:0]          ll_r;
  logic                    neg_r;
  frac_t                   u_r;
  frac_t                   t_r;

  logic signed [SW-1:0]    sum;
  horn_t                   out_r;

  // split both operands into halves
  assign {mh, ml} = cell_in.u;
  assign ph       = cell_in.p[PW-1:SPLIT];
  assign pl       = cell_in.p[SPLIT-1:0];

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      hh_r  <= $signed({1'b0, mh}) * ph;
      hl_r  <= mh * pl;
      lh_r  <= $signed({1'b0, ml}) * ph;
      ll_r  <= ml * pl;
      neg_r <= cell_in.neg;
      u_r   <= cell_in.u;
      t_r   <= cell_in.t;
    end
  end

  // recombine and add the coefficient aligned to the binary point
  always_comb begin
    sum = (SW'(hh_r) <<< (2 * SPLIT))
        + (SW'(hl_r) << SPLIT)
        + (SW'(lh_r) <<< SPLIT)
        + SW'(ll_r)
        + (SW'(coef) <<< FB);
  end

  // floor back to accumulator format
  always_ff @(posedge clk) begin
    if (en) begin
      out_r.p   <= sum[FB +: PW];
      out_r.neg <= neg_r;
      out_r.u   <= u_r;
      out_r.t   <= t_r;
    end
  end

  assign cell_out = out_r;

endmodule

`default_nettype wire

// ===== hw/rtl/eulr_sine.sv =====
// binary angle to q1.15 sine: quadrant fold, square, chain of horner cells, rounding
`default_nettype none

module eulr_sine (
  input  logic            clk,
  input  logic            en,
  input  eulr_pkg::angle_t angle,
  output eulr_pkg::trig_t  sin_out
);
  import eulr_pkg::*;

  localparam int RW  = QB + 1;
  localparam int SW2 = PW + TRIG_FRAC + 1;
  localparam logic [RW:0]   HALF_TURN = (RW + 1)'(2 ** (QB + 1));
  localparam logic [RW-1:0] QTR       = RW'(2 ** QB);

  logic [RW-1:0]       b;
  logic [RW-1:0]       r;
  logic [RW-1:0]       r0_r;
  logic                neg0_r;
  logic [2*RW-1:0]     sq;
  horn_t               h0_r;
  horn_t               hc [NT];
  horn_t               fin_in;
  horn_t               fin;
  logic signed [SW2-1:0] y;
  trig_t               mag;
  trig_t               sin_r;

  // fold the angle into the first quadrant
  assign b = angle[ANGLE_WIDTH-2:0];
  assign r = (b > QTR) ? RW'(HALF_TURN - {1'b0, b}) : b;

  always_ff @(posedge clk) begin
    if (en) begin
      r0_r   <= r;
      neg0_r <= angle[ANGLE_WIDTH-1];
    end
  end

  // t and t squared in polynomial fraction format, top coefficient seeds p
  assign sq = r0_r * r0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      h0_r.neg <= neg0_r;
      h0_r.u   <= frac_t'({sq, {(FB - 2 * QB){1'b0}}});
      h0_r.t   <= {r0_r, {(FB - QB){1'b0}}};
      h0_r.p   <= COEF[NT-1];
    end
  end

  assign hc[0] = h0_r;

  // horner chain over t squared
  for (genvar j = 0; j < NT - 1; j++) begin : g_cell
    eulr_mac_cell u_cell (
      .clk      (clk),
      .en       (en),
      .cell_in  (hc[j]),
      .coef     (COEF[NT-2-j]),
      .cell_out (hc[j+1])
    );
  end

  // last cell multiplies by t
  always_comb begin
    fin_in   = hc[NT-1];
    fin_in.u = hc[NT-1].t;
  end

  eulr_mac_cell u_cell_t (
    .clk      (clk),
    .en       (en),
    .cell_in  (fin_in),
    .coef     ('0),
    .cell_out (fin)
  );

  // scale by 32767, round half up, restore the sign
  assign y   = (SW2'(fin.p) <<< TRIG_FRAC) - SW2'(fin.p) + (SW2'(1) << (FB - 1));
  assign mag = y[FB +: TRIG_WIDTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= fin.neg ? -mag : mag;
    end
  end

  assign sin_out = sin_r;

endmodule

`default_nettype wire

// ===== hw/rtl/eulr_rot_cell.sv =====
// one plane rotation: a' = a*c - b*s, b' = a*s + b*c, floor by 2^15, saturate
`default_nettype none

module eulr_rot_cell (
  input  logic            clk,
  input  logic            en,
  input  eulr_pkg::coord_t a_in,
  input  eulr_pkg::coord_t b_in,
  input  eulr_pkg::cs_t    cs,
  output eulr_pkg::coord_t a_out,
  output eulr_pkg::coord_t b_out
);
  import eulr_pkg::*;

  localparam int PRW  = COORD_WIDTH + TRIG_WIDTH;
  localparam int SUMW = PRW + 1;
  localparam int QW   = SUMW - TRIG_FRAC;

  localparam coord_t CMAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

  logic signed [PRW-1:0]  ac_r;
  logic signed [PRW-1:0]  bs_r;
  logic signed [PRW-1:0]  as_r;
  logic signed [PRW-1:0]  bc_r;
  logic signed [SUMW-1:0] da;
  logic signed [SUMW-1:0] db;
  coord_t                 a_r;
  coord_t                 b_r;

  // clamp a floored sum to the coordinate range
  function automatic coord_t sat(input logic [QW-1:0] q);
    logic [QW-COORD_WIDTH:0] top;
    top = q[QW-1:COORD_WIDTH-1];
    if ((&top) || !(|top)) begin
      return q[COORD_WIDTH-1:0];
    end
    return q[QW-1] ? CMIN : CMAX;
  endfunction

  // products
  always_ff @(posedge clk) begin
    if (en) begin
      ac_r <= a_in * cs.c;
      bs_r <= b_in * cs.s;
      as_r <= a_in * cs.s;
      bc_r <= b_in * cs.c;
    end
  end

  // sums
  assign da = SUMW'(ac_r) - SUMW'(bs_r);
  assign db = SUMW'(as_r) + SUMW'(bc_r);

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= sat(da[SUMW-1:TRIG_FRAC]);
      b_r <= sat(db[SUMW-1:TRIG_FRAC]);
    end
  end

  assign a_out = a_r;
  assign b_out = b_r;

endmodule

`default_nettype wire

// ===== hw/rtl/euler_xyz_vector_rotate_unit.sv =====
// a beat passes the sine units, then the rotations about x, y and z, then the output register
// throughput: one beat per cycle when not stalled; every sine runs down a chain of ten
//   two-stage mac cells, followed by three two-stage rotation cells, all advancing together
// an output register plus one skid register take results while the sink stalls
// reset (synchronous, active low) clears the valid bits of the pipeline and both output slots
`default_nettype none

module euler_xyz_vector_rotate_unit (
  input  logic      clk,
  input  logic      rst_n,
  eulr_in_if.sink   in_if,
  eulr_out_if.source out_if
);
  import eulr_pkg::*;

  logic           en;
  logic           last_vld;
  logic [LAT-1:0] v_r;

  angle_t cos_ax;
  angle_t cos_ay;
  angle_t cos_az;
  trig_t  sx, cx, sy, cy, sz, cz;
  cs_t    cs_x;

  vec3_t  vd_r [SIN_LAT];
  cs_t    ty_r [ROT_LAT];
  cs_t    tz_r [2*ROT_LAT];
  coord_t xd_r [ROT_LAT];
  coord_t yd_r [ROT_LAT];
  coord_t zd_r [ROT_LAT];

  coord_t y1, z1, z2, x2, x3, y3;
  vec3_t  last;
  vec3_t  out_r;
  vec3_t  skid_r;
  logic   out_vld_r;
  logic   skid_vld_r;

  // pipeline moves whenever the skid slot is free
  assign en          = !skid_vld_r;
  assign in_if.ready = en;
  assign last_vld    = v_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_if.valid};
    end
  end

  // sine and cosine of each angle
  assign cos_ax = in_if.angle_x + QUARTER_TURN;
  assign cos_ay = in_if.angle_y + QUARTER_TURN;
  assign cos_az = in_if.angle_z + QUARTER_TURN;

  eulr_sine u_sin_x (.clk(clk), .en(en), .angle(in_if.angle_x), .sin_out(sx));
  eulr_sine u_cos_x (.clk(clk), .en(en), .angle(cos_ax),        .sin_out(cx));
  eulr_sine u_sin_y (.clk(clk), .en(en), .angle(in_if.angle_y), .sin_out(sy));
  eulr_sine u_cos_y (.clk(clk), .en(en), .angle(cos_ay),        .sin_out(cy));
  eulr_sine u_sin_z (.clk(clk), .en(en), .angle(in_if.angle_z), .sin_out(sz));
  eulr_sine u_cos_z (.clk(clk), .en(en), .angle(cos_az),        .sin_out(cz));

  // vector waits for its trig values
  always_ff @(posedge clk) begin
    if (en) begin
      vd_r[0] <= '{x: in_if.vec_x, y: in_if.vec_y, z: in_if.vec_z};
      for (int i = 1; i < SIN_LAT; i++) begin
        vd_r[i] <= vd_r[i-1];
      end
    end
  end

  // trig values and components that wait for the earlier rotations
  always_ff @(posedge clk) begin
    if (en) begin
      ty_r[0] <= '{c: cy, s: sy};
      tz_r[0] <= '{c: cz, s: sz};
      xd_r[0] <= vd_r[SIN_LAT-1].x;
      yd_r[0] <= y1;
      zd_r[0] <= z2;
      for (int i = 1; i < ROT_LAT; i++) begin
        ty_r[i] <= ty_r[i-1];
        xd_r[i] <= xd_r[i-1];
        yd_r[i] <= yd_r[i-1];
        zd_r[i] <= zd_r[i-1];
      end
      for (int i = 1; i < 2 * ROT_LAT; i++) begin
        tz_r[i] <= tz_r[i-1];
      end
    end
  end

  assign cs_x = '{c: cx, s: sx};

  // about x: (y, z)
  eulr_rot_cell u_rot_x (
    .clk(clk), .en(en), .a_in(vd_r[SIN_LAT-1].y), .b_in(vd_r[SIN_LAT-1].z),
    .cs(cs_x), .a_out(y1), .b_out(z1)
  );

  // about y: (z, x)
  eulr_rot_cell u_rot_y (
    .clk(clk), .en(en), .a_in(z1), .b_in(xd_r[ROT_LAT-1]),
    .cs(ty_r[ROT_LAT-1]), .a_out(z2), .b_out(x2)
  );

  // about z: (x, y)
  eulr_rot_cell u_rot_z (
    .clk(clk), .en(en), .a_in(x2), .b_in(yd_r[ROT_LAT-1]),
    .cs(tz_r[2*ROT_LAT-1]), .a_out(x3), .b_out(y3)
  );

  assign last = '{x: x3, y: y3, z: zd_r[ROT_LAT-1]};

  // output register and skid slot control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_vld_r && out_if.ready) begin
      if (skid_vld_r) begin
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= last_vld;
      end
    end else if (!out_vld_r) begin
      out_vld_r <= last_vld;
    end else if (last_vld && en) begin
      skid_vld_r <= 1'b1;
    end
  end

  // output register and skid slot data
  always_ff @(posedge clk) begin
    if (out_vld_r && out_if.ready) begin
      if (skid_vld_r) begin
        out_r <= skid_r;
      end else begin
        out_r <= last;
      end
    end else if (!out_vld_r) begin
      out_r <= last;
    end else if (en) begin
      skid_r <= last;
    end
  end

  assign out_if.valid = out_vld_r;
  assign out_if.rot_x = out_r.x;
  assign out_if.rot_y = out_r.y;
  assign out_if.rot_z = out_r.z;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid slot holds a beat while the output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_if.ready && !skid_vld_r && last_vld) |=> skid_vld_r)
    else $error("finished beat not caught by the skid slot");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && out_if.ready) |=> (out_vld_r && !skid_vld_r))
    else $error("skid slot did not move to the output register");

  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(last_vld))
    else $error("output beat appeared without a finished pipeline beat");
`endif

endmodule

`default_nettype wire
